@@ hdl/cacr_pkg.sv @@
// Package for the central atom class renumbering block.
// Holds field widths, register indexes and the flag group that travels down the cell chain.
// Used by cacr_select, cacr_cell and central_atom_class_renumber_top.
`timescale 1ns / 1ps

package cacr_pkg;

    localparam int POT_W      = 8;
    localparam int NUM_W      = 7;
    localparam int KEY_W      = POT_W + NUM_W;
    localparam int CZ_W       = 7;
    localparam int CI_W       = 8;
    localparam int MATCH_W    = 9;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam int MAX_CLASSES_DEFAULT = 16;

    localparam logic [MATCH_W-1:0]   MATCH_MAX        = '1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_Z    = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTRAL_INST = 1'd1;

    typedef struct packed {
        logic skip;          // central atom, takes no class from the table
        logic found;         // a cell has already given this item its class
        logic last;          // final atom of the set
        logic central_found; // a central atom has been seen in this set so far
    } tok_flags_t;

endpackage

@@ hdl/cacr_select.sv @@
// Central atom selection stage at the head of the cell chain.
// Tracks the match count and set status and registers the item for the first cell.
// Depends on cacr_pkg.
`timescale 1ns / 1ps

module cacr_select
    import cacr_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              accept,
    input  logic [POT_W-1:0]  potential_code,
    input  logic [NUM_W-1:0]  atomic_number,
    input  logic              last_atom,
    input  logic [CZ_W-1:0]   central_z,
    input  logic [CI_W-1:0]   central_instance,
    output logic              tok_valid,
    output logic [KEY_W-1:0]  tok_key,
    output tok_flags_t        tok_flags
);

    logic [MATCH_W-1:0] match_count_reg, match_count_next;
    logic               central_seen_reg;
    logic               first_pending_reg;
    logic               tok_valid_reg;
    logic [KEY_W-1:0]   tok_key_reg;
    tok_flags_t         tok_flags_reg, tok_flags_next;
    logic               central;
    logic               num_match;

    assign num_match = (atomic_number == central_z);

    always_comb begin
        central = 1'b0;
        match_count_next = match_count_reg;
        if (central_z == '0) begin
            central = first_pending_reg && (central_instance == '0) && !central_seen_reg;
        end else if (num_match) begin
            central = !central_seen_reg
                && (match_count_reg == {{(MATCH_W-CI_W){1'b0}}, central_instance});
            if (match_count_reg != MATCH_MAX) begin
                match_count_next = match_count_reg + 1'b1;
            end
        end
        tok_flags_next.skip          = central;
        tok_flags_next.found         = 1'b0;
        tok_flags_next.last          = last_atom;
        tok_flags_next.central_found = central_seen_reg || central;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_count_reg   <= '0;
            central_seen_reg  <= 1'b0;
            first_pending_reg <= 1'b1;
            tok_valid_reg     <= 1'b0;
        end else begin
            if (adv) begin
                tok_valid_reg <= accept;
            end
            if (accept) begin
                if (last_atom) begin
                    match_count_reg   <= '0;
                    central_seen_reg  <= 1'b0;
                    first_pending_reg <= 1'b1;
                end else begin
                    match_count_reg   <= match_count_next;
                    central_seen_reg  <= tok_flags_next.central_found;
                    first_pending_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            tok_key_reg   <= {potential_code, atomic_number};
            tok_flags_reg <= tok_flags_next;
        end
    end

    assign tok_valid = tok_valid_reg;
    assign tok_key   = tok_key_reg;
    assign tok_flags = tok_flags_reg;

endmodule

@@ hdl/cacr_cell.sv @@
// One cell of the key chain: holds one pair key and whether it is in use.
// An item passing through takes this cell's class on a hit or claims the cell when it is free.
// Depends on cacr_pkg.
`timescale 1ns / 1ps

module cacr_cell
    import cacr_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT,
    parameter int CELL_INDEX  = 0,
    parameter int CID_W       = $clog2(MAX_CLASSES + 1)
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic              in_valid,
    input  logic [KEY_W-1:0]  in_key,
    input  tok_flags_t        in_flags,
    input  logic [CID_W-1:0]  in_class,
    input  logic [CID_W-1:0]  in_cnt,
    output logic              out_valid,
    output logic [KEY_W-1:0]  out_key,
    output tok_flags_t        out_flags,
    output logic [CID_W-1:0]  out_class,
    output logic [CID_W-1:0]  out_cnt
);

    localparam logic [CID_W-1:0] CELL_CLASS = CID_W'(CELL_INDEX + 1);

    logic              used_reg;
    logic [KEY_W-1:0]  key_reg;
    logic              out_valid_reg;
    logic [KEY_W-1:0]  out_key_reg;
    tok_flags_t        out_flags_reg;
    logic [CID_W-1:0]  out_class_reg;
    logic [CID_W-1:0]  out_cnt_reg;
    logic              open;
    logic              hit;
    logic              claim;
    logic              take;
    logic              used_after;
    tok_flags_t        flags_next;

    always_comb begin
        open       = !in_flags.skip && !in_flags.found;
        hit        = used_reg && (key_reg == in_key);
        claim      = open && !used_reg;
        take       = open && (hit || claim);
        used_after = used_reg || claim;
        flags_next = in_flags;
        flags_next.found = in_flags.found || take;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= in_valid;
            if (in_valid) begin
                used_reg <= in_flags.last ? 1'b0 : used_after;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && in_valid) begin
            if (claim) begin
                key_reg <= in_key;
            end
            out_key_reg   <= in_key;
            out_flags_reg <= flags_next;
            out_class_reg <= take ? CELL_CLASS : in_class;
            out_cnt_reg   <= in_cnt + CID_W'(used_after);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_key   = out_key_reg;
    assign out_flags = out_flags_reg;
    assign out_class = out_class_reg;
    assign out_cnt   = out_cnt_reg;

endmodule

@@ hdl/central_atom_class_renumber_top.sv @@
// Top level of the central atom class renumbering block.
// Instantiates cacr_select and a chain of cacr_cell, and holds the output register.
// Depends on cacr_pkg.
`timescale 1ns / 1ps

// The block takes one atom per clock cycle while the result side does not stall,
// and gives one result per atom, in order. Each atom passes through a selection stage,
// then one cell per key table entry (MAX_CLASSES cells), then the output register.
// The pipeline depth is set by the number of cells; the rate stays at one item per cycle
// while the output is not stalled. A stall on the result side holds the whole chain.
// The last result of a set carries central_found, class_count and table_overflow;
// when central_found is 0 the class ids of that set should be discarded.

module central_atom_class_renumber_top
    import cacr_pkg::*;
#(
    parameter int MAX_CLASSES = MAX_CLASSES_DEFAULT,
    parameter int CID_W       = $clog2(MAX_CLASSES + 1),
    parameter int CCNT_W      = $clog2(MAX_CLASSES + 2),
    parameter int OUT_BITS    = CID_W + CCNT_W + 3,
    parameter int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wen,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // potential_code, atomic_number, zero fill
    input  logic [15:0]             s_tdata,
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // class_id, is_central, central_found, class_count, table_overflow, zero fill
    output logic [OUT_DATA_W-1:0]   m_tdata,
    output logic                    m_tlast
);

    logic [CZ_W-1:0]    central_z_reg;
    logic [CI_W-1:0]    central_inst_reg;
    logic               adv;
    logic               accept;

    logic               chain_valid [MAX_CLASSES+1];
    logic [KEY_W-1:0]   chain_key   [MAX_CLASSES+1];
    tok_flags_t         chain_flags [MAX_CLASSES+1];
    logic [CID_W-1:0]   chain_class [MAX_CLASSES+1];
    logic [CID_W-1:0]   chain_cnt   [MAX_CLASSES+1];

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                  m_tlast_reg;
    logic                  ovf_seen_reg;

    tok_flags_t         tail_flags;
    logic               new_ovf;
    logic               ovf;
    logic [CID_W-1:0]   class_fin;
    logic [CCNT_W-1:0]  class_count;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign accept   = s_tvalid && adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            central_z_reg    <= '0;
            central_inst_reg <= '0;
        end else if (cfg_wen) begin
            unique case (cfg_index)
                REG_CENTRAL_Z:    central_z_reg    <= cfg_wdata[CZ_W-1:0];
                REG_CENTRAL_INST: central_inst_reg <= cfg_wdata[CI_W-1:0];
                default: ;
            endcase
        end
    end

    cacr_select u_select (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .adv              (adv),
        .accept           (accept),
        .potential_code   (s_tdata[POT_W-1:0]),
        .atomic_number    (s_tdata[KEY_W-1:POT_W]),
        .last_atom        (s_tlast),
        .central_z        (central_z_reg),
        .central_instance (central_inst_reg),
        .tok_valid        (chain_valid[0]),
        .tok_key          (chain_key[0]),
        .tok_flags        (chain_flags[0])
    );

    assign chain_class[0] = '0;
    assign chain_cnt[0]   = '0;

    for (genvar i = 0; i < MAX_CLASSES; i++) begin : g_cell
        cacr_cell #(
            .MAX_CLASSES (MAX_CLASSES),
            .CELL_INDEX  (i),
            .CID_W       (CID_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv       (adv),
            .in_valid  (chain_valid[i]),
            .in_key    (chain_key[i]),
            .in_flags  (chain_flags[i]),
            .in_class  (chain_class[i]),
            .in_cnt    (chain_cnt[i]),
            .out_valid (chain_valid[i+1]),
            .out_key   (chain_key[i+1]),
            .out_flags (chain_flags[i+1]),
            .out_class (chain_class[i+1]),
            .out_cnt   (chain_cnt[i+1])
        );
    end

    always_comb begin
        tail_flags = chain_flags[MAX_CLASSES];
        new_ovf    = !tail_flags.skip && !tail_flags.found;
        ovf        = ovf_seen_reg || new_ovf;
        if (tail_flags.found) begin
            class_fin = chain_class[MAX_CLASSES];
        end else if (tail_flags.skip) begin
            class_fin = '0;
        end else begin
            class_fin = CID_W'(MAX_CLASSES);
        end
        class_count = tail_flags.last
            ? (CCNT_W'(chain_cnt[MAX_CLASSES]) + 1'b1) : '0;
        m_tdata_next = '0;
        m_tdata_next[OUT_BITS-1:0] = {ovf, class_count,
                                      tail_flags.last && tail_flags.central_found,
                                      tail_flags.skip, class_fin};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            ovf_seen_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= chain_valid[MAX_CLASSES];
            if (chain_valid[MAX_CLASSES]) begin
                ovf_seen_reg <= tail_flags.last ? 1'b0 : ovf;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && chain_valid[MAX_CLASSES]) begin
            m_tdata_reg <= m_tdata_next;
            m_tlast_reg <= tail_flags.last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

endmodule

@@ bench/tb_central_atom_class_renumber_top.sv @@
// Self-checking testbench for central_atom_class_renumber_top.
// Drives atom items through the input stream, predicts each class result and checks the output
// stream field by field under random idling on both sides. Depends on cacr_pkg and the DUT.
`timescale 1ns / 1ps

module tb_central_atom_class_renumber_top;
    import cacr_pkg::*;

    localparam int NUM_CLASSES = MAX_CLASSES_DEFAULT;
    localparam int CID_W       = $clog2(NUM_CLASSES + 1);
    localparam int CNT_W       = $clog2(NUM_CLASSES + 2);
    localparam int OUT_DATA_W  = ((CID_W + CNT_W + 3 + 7) / 8) * 8;
    localparam int LATENCY     = NUM_CLASSES + 2;
    localparam int CYCLE_LIMIT = 300000;
    localparam int ITEM_TARGET = 1050;

    typedef struct packed {
        logic [POT_W-1:0] pot;
        logic [NUM_W-1:0] num;
        logic             last;
    } atom_t;

    typedef struct packed {
        logic [CID_W-1:0] class_id;
        logic             is_central;
        logic             end_of_set;
        logic             central_found;
        logic [CNT_W-1:0] class_count;
        logic             table_overflow;
    } atom_result_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [15:0]           s_tdata   = '0;
    logic                  s_tlast   = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    central_atom_class_renumber_top #(
        .MAX_CLASSES(NUM_CLASSES)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wen  (cfg_wen),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #5 aclk = ~aclk;

    atom_t        atoms_to_send[$];
    atom_result_t classes_due[$];
    atom_t        on_bus;
    atom_result_t want;
    atom_result_t got;
    int           mismatches  = 0;
    int           atoms_queued = 0;
    int           cycle_count = 0;
    int           send_wait   = 0;
    int           recv_wait   = 0;
    bit           steady_send = 1'b0;
    bit           steady_recv = 1'b0;

    // Shadow of the configuration registers and of the per-set state.
    logic [CZ_W-1:0]    cz_now = '0;
    logic [CI_W-1:0]    ci_now = '0;
    logic [KEY_W-1:0]   pair_keys[NUM_CLASSES];
    int                 n_keys        = 0;
    logic [MATCH_W-1:0] z_hits        = '0;
    logic               central_taken = 1'b0;
    logic               at_first      = 1'b1;
    logic               overflowed    = 1'b0;

    task automatic report_mismatch(string what, logic [31:0] seen, logic [31:0] wanted);
        if (mismatches < 50)
            $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, seen,
                     wanted);
        mismatches++;
    endtask

    function automatic atom_result_t renumber_atom(atom_t a);
        atom_result_t     r;
        logic [KEY_W-1:0] pair;
        logic             central;
        logic             hit;
        r       = '0;
        pair    = {a.pot, a.num};
        central = 1'b0;
        hit     = 1'b0;
        if (cz_now == '0) begin
            if (at_first && ci_now == '0 && !central_taken)
                central = 1'b1;
        end else if (a.num == cz_now) begin
            if (!central_taken && z_hits == ci_now)
                central = 1'b1;
            if (z_hits != MATCH_MAX)
                z_hits++;
        end
        at_first = 1'b0;
        if (central) begin
            central_taken = 1'b1;
        end else begin
            for (int i = 0; i < n_keys; i++) begin
                if (!hit && pair_keys[i] == pair) begin
                    hit        = 1'b1;
                    r.class_id = CID_W'(i + 1);
                end
            end
            if (!hit) begin
                if (n_keys < NUM_CLASSES) begin
                    pair_keys[n_keys] = pair;
                    n_keys++;
                    r.class_id = CID_W'(n_keys);
                end else begin
                    overflowed = 1'b1;
                    r.class_id = CID_W'(NUM_CLASSES);
                end
            end
        end
        r.is_central     = central;
        r.end_of_set     = a.last;
        r.central_found  = a.last && central_taken;
        r.class_count    = a.last ? CNT_W'(n_keys + 1) : '0;
        r.table_overflow = overflowed;
        if (a.last) begin
            n_keys        = 0;
            z_hits        = '0;
            central_taken = 1'b0;
            at_first      = 1'b1;
            overflowed    = 1'b0;
        end
        return r;
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_wait = 0;
        end else begin
            if (s_tvalid && s_tready)
                classes_due.push_back(renumber_atom(on_bus));
            if (!s_tvalid || s_tready) begin
                if (send_wait > 0 || atoms_to_send.size() == 0) begin
                    if (send_wait > 0)
                        send_wait--;
                    s_tvalid <= 1'b0;
                end else begin
                    on_bus = atoms_to_send.pop_front();
                    s_tdata  <= {1'b0, on_bus.num, on_bus.pot};
                    s_tlast  <= on_bus.last;
                    s_tvalid <= 1'b1;
                    send_wait = steady_send ? 0 : $urandom_range(0, 19);
                    if ($urandom_range(0, 29) == 0)
                        steady_send = !steady_send;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.class_id       = m_tdata[CID_W-1:0];
                got.is_central     = m_tdata[CID_W];
                got.central_found  = m_tdata[CID_W+1];
                got.class_count    = m_tdata[CID_W+2 +: CNT_W];
                got.table_overflow = m_tdata[CID_W+2+CNT_W];
                got.end_of_set     = m_tlast;
                if (classes_due.size() == 0) begin
                    report_mismatch("result with no atom pending", m_tdata, '0);
                end else begin
                    want = classes_due.pop_front();
                    if (got.class_id !== want.class_id)
                        report_mismatch("class_id", got.class_id, want.class_id);
                    if (got.is_central !== want.is_central)
                        report_mismatch("is_central", got.is_central, want.is_central);
                    if (got.end_of_set !== want.end_of_set)
                        report_mismatch("end_of_set", got.end_of_set, want.end_of_set);
                    if (got.central_found !== want.central_found)
                        report_mismatch("central_found", got.central_found, want.central_found);
                    if (got.class_count !== want.class_count)
                        report_mismatch("class_count", got.class_count, want.class_count);
                    if (got.table_overflow !== want.table_overflow)
                        report_mismatch("table_overflow", got.table_overflow,
                                        want.table_overflow);
                end
                recv_wait = steady_recv ? 0 : $urandom_range(0, 19);
                if ($urandom_range(0, 29) == 0)
                    steady_recv = !steady_recv;
            end
            if (recv_wait > 0) begin
                recv_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic queue_atom(logic [POT_W-1:0] pot, logic [NUM_W-1:0] num, logic last);
        atom_t a;
        a.pot  = pot;
        a.num  = num;
        a.last = last;
        atoms_to_send.push_back(a);
        atoms_queued++;
    endtask

    // Atoms are drawn mostly from a small pool of pairs so that classes repeat;
    // a pool larger than the key table makes it overflow.
    task automatic queue_set(int n, bit close, int z_pct);
        logic [POT_W-1:0] pots[24];
        logic [NUM_W-1:0] nums[24];
        logic [POT_W-1:0] pot;
        logic [NUM_W-1:0] num;
        int               kinds;
        int               pick;
        kinds = $urandom_range(1, 20);
        for (int k = 0; k < kinds; k++) begin
            pots[k] = POT_W'($urandom);
            nums[k] = NUM_W'($urandom);
        end
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, kinds - 1);
            pot  = pots[pick];
            num  = nums[pick];
            if ($urandom_range(0, 9) == 0) begin
                pot = POT_W'($urandom);
                num = NUM_W'($urandom);
            end
            if (cz_now != '0 && $urandom_range(0, 99) < z_pct)
                num = cz_now;
            queue_atom(pot, num, close && (i == n - 1));
        end
    endtask

    // Checked between rising edges so that the driver and the monitor have settled.
    task automatic drain_block();
        do
            @(negedge aclk);
        while (atoms_to_send.size() != 0 || s_tvalid || classes_due.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge aclk);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        if (idx == REG_CENTRAL_Z)
            cz_now = val[CZ_W-1:0];
        else if (idx == REG_CENTRAL_INST)
            ci_now = val[CI_W-1:0];
    endtask

    initial begin
        logic [CZ_W-1:0] z;
        logic [CI_W-1:0] inst;
        logic            pad;
        int              nsets;
        int              n;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Selector at its reset value: the first atom is central and its pair is not reused.
        queue_atom(8'hFF, 7'h7F, 1'b0);
        queue_atom(8'hFF, 7'h7F, 1'b0);
        queue_atom(8'h00, 7'h00, 1'b1);
        queue_atom(8'h5A, 7'h2A, 1'b1);
        drain_block();

        // A zero selector with a nonzero instance picks no atom.
        write_reg(REG_CENTRAL_INST, 8'd5);
        queue_atom(8'h11, 7'h00, 1'b1);
        drain_block();

        // The top bit of the selector write is dropped; too few matches for the instance.
        write_reg(REG_CENTRAL_Z, 8'hFF);
        write_reg(REG_CENTRAL_INST, 8'hFF);
        queue_atom(8'hFF, 7'h7F, 1'b0);
        queue_atom(8'h00, 7'h7F, 1'b1);
        drain_block();

        // Second match is central and seventeen distinct pairs overfill the key table.
        write_reg(REG_CENTRAL_Z, 8'd26);
        write_reg(REG_CENTRAL_INST, 8'd1);
        for (int i = 0; i < 18; i++)
            queue_atom(POT_W'(i), 7'd26, i == 17);
        drain_block();

        // One long set reaches the highest instance.
        write_reg(REG_CENTRAL_Z, CFG_DATA_W'($urandom_range(1, 127)));
        write_reg(REG_CENTRAL_INST, 8'd255);
        queue_set(300, 1'b1, 95);
        drain_block();

        while (atoms_queued < ITEM_TARGET) begin
            case ($urandom_range(0, 5))
                0:       z = '0;
                1:       z = 7'd127;
                default: z = CZ_W'($urandom_range(1, 127));
            endcase
            case ($urandom_range(0, 7))
                0, 1, 2: inst = '0;
                3, 4:    inst = CI_W'($urandom_range(1, 3));
                5:       inst = 8'd255;
                default: inst = CI_W'($urandom_range(0, 255));
            endcase
            if (z == '0 && $urandom_range(0, 3) != 0)
                inst = '0;
            pad = 1'($urandom_range(0, 1));
            write_reg(REG_CENTRAL_Z, {pad, z});
            write_reg(REG_CENTRAL_INST, inst);
            nsets = $urandom_range(1, 4);
            for (int s = 0; s < nsets; s++) begin
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(1, 24);
                queue_set(n, (s < nsets - 1) || ($urandom_range(0, 3) != 0), 35);
            end
            drain_block();
        end

        repeat (4 * LATENCY) @(posedge aclk);
        if (classes_due.size() != 0)
            report_mismatch("results never delivered", classes_due.size(), '0);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
